// ===== rtl/core/crcfg_pkg.sv =====
// Shared types and constants for the CRC frame generator and checker.
// No dependencies; every other file of the block depends on this package.
package crcfg_pkg;

  localparam int MAX_DATA_BITS = 32;
  localparam int MAX_CRC_BITS  = 31;

  localparam int DATA_W  = 32;
  localparam int FCS_W   = 31;
  localparam int POLY_W  = 32;
  localparam int CWIDTH_W = 5;
  localparam int FLEN_W  = 6;

  // One cell per bit of the longest message: data bits, then check bits.
  localparam int NUM_CELLS = MAX_DATA_BITS + MAX_CRC_BITS;
  localparam int MSG_W     = NUM_CELLS;

  localparam logic [POLY_W-1:0]   POLY_RESET   = 32'd263;
  localparam logic [CWIDTH_W-1:0] CWIDTH_RESET = 5'd8;
  localparam logic [FLEN_W-1:0]   FLEN_RESET   = 6'd20;

  typedef enum logic [1:0] {
    REG_POLY         = 2'd0,
    REG_CRC_WIDTH    = 2'd1,
    REG_FRAME_LENGTH = 2'd2
  } crcfg_reg_t;

  // Values derived from the configuration registers.
  typedef struct packed {
    logic [FCS_W-1:0]    wmask;
    logic [FCS_W-1:0]    topmask;
    logic [FCS_W-1:0]    gen;
    logic [CWIDTH_W-1:0] width;
    logic [FLEN_W-1:0]   len;
    logic                bad;
  } crcfg_setup_t;

  // What one cell hands to the next.
  typedef struct packed {
    logic             action;
    logic [FCS_W-1:0] rem;
    logic [MSG_W-1:0] msg;
  } crcfg_stage_t;

endpackage

// ===== rtl/core/crcfg_if.sv =====
// Request and response channel interfaces with valid/ready handshakes.
// Depends on crcfg_pkg for the field widths.
interface crcfg_req_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [crcfg_pkg::DATA_W-1:0] data;
  logic [crcfg_pkg::FCS_W-1:0]  received_fcs;

  modport source (output valid, output action, output data, output received_fcs,
                  input ready);
  modport sink   (input valid, input action, input data, input received_fcs,
                  output ready);
endinterface

interface crcfg_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [crcfg_pkg::FCS_W-1:0] remainder;
  logic                        passed;
  logic                        bad_setup;

  modport source (output valid, output remainder, output passed, output bad_setup,
                  input ready);
  modport sink   (input valid, input remainder, input passed, input bad_setup,
                  output ready);
endinterface

// ===== rtl/core/crc_frame_generate_check_core.sv =====
// Top level of the CRC frame generator and checker: configuration registers,
// message assembly, the chain of division cells and the output register.
// Depends on crcfg_pkg, crcfg_if, crcfg_setup and crcfg_cell.
//
// Usage:
//   Requests arrive on req (action, data, received_fcs); one response per
//   request leaves on rsp (remainder, passed, bad_setup). Both channels use
//   valid/ready. The frame's data bits, followed by the check bits (zeros
//   when generating, received_fcs when verifying), pass through a row of 63
//   cells, one message bit per cell. Leading zero bits leave the remainder
//   at zero, so every frame length uses the same row.
//   A request accepted at one edge loads into the first cell at that edge,
//   passes through each cell in turn and then into the output register.
//   Throughput: one request per cycle while the row is not backed up; the
//   length of the cell row sets the latency, not the rate.
//   Stalls: when rsp.ready is low the response holds; each cell still takes
//   new data while it or any register ahead of it is empty, so req.ready
//   stays high until the whole row and the output register are full.
//   Reset clears all valid flags and restores poly, crc_width and
//   frame_length to 263, 8 and 20. The user writes registers through cfg_*
//   only while no request is in flight; the block itself does not enforce it.
module crc_frame_generate_check_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [1:0]                        cfg_index,
  input  logic [crcfg_pkg::POLY_W-1:0]      cfg_data,
  crcfg_req_if.sink                         req,
  crcfg_rsp_if.source                       rsp
);
  import crcfg_pkg::*;

  logic [POLY_W-1:0]   poly;
  logic [CWIDTH_W-1:0] crc_width;
  logic [FLEN_W-1:0]   frame_length;

  crcfg_setup_t setup;

  logic         stage_valid [0:NUM_CELLS];
  logic         stage_ready [0:NUM_CELLS];
  crcfg_stage_t stage_data  [0:NUM_CELLS];

  logic [DATA_W-1:0] data_mask;
  logic [FCS_W-1:0]  fcs_bits;
  logic [MSG_W-1:0]  msg;
  crcfg_stage_t      last;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly         <= POLY_RESET;
      crc_width    <= CWIDTH_RESET;
      frame_length <= FLEN_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_POLY:         poly         <= cfg_data;
        REG_CRC_WIDTH:    crc_width    <= cfg_data[CWIDTH_W-1:0];
        REG_FRAME_LENGTH: frame_length <= cfg_data[FLEN_W-1:0];
        default: ;
      endcase
    end
  end

  crcfg_setup u_setup (
    .poly         (poly),
    .crc_width    (crc_width),
    .frame_length (frame_length),
    .setup        (setup)
  );

  // The message is right aligned: data bits above the check bits.
  always_comb begin
    data_mask = DATA_W'((33'd1 << setup.len) - 33'd1);
    fcs_bits  = req.action ? (req.received_fcs & setup.wmask) : '0;
    msg       = (MSG_W'(req.data & data_mask) << setup.width) | MSG_W'(fcs_bits);
  end

  assign stage_valid[0]       = req.valid;
  assign stage_data[0].action = req.action;
  assign stage_data[0].rem    = '0;
  assign stage_data[0].msg    = msg;
  assign req.ready            = stage_ready[0];

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    crcfg_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .setup     (setup),
      .in_valid  (stage_valid[k]),
      .in_ready  (stage_ready[k]),
      .in_stage  (stage_data[k]),
      .out_valid (stage_valid[k+1]),
      .out_ready (stage_ready[k+1]),
      .out_stage (stage_data[k+1])
    );
  end

  assign last                   = stage_data[NUM_CELLS];
  assign stage_ready[NUM_CELLS] = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (stage_ready[NUM_CELLS]) begin
      rsp.valid <= stage_valid[NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready[NUM_CELLS] && stage_valid[NUM_CELLS]) begin
      rsp.remainder <= last.rem;
      rsp.passed    <= last.action && !setup.bad && (last.rem == '0);
      rsp.bad_setup <= setup.bad;
    end
  end

endmodule

// ===== rtl/core/crcfg_setup.sv =====
// Derives masks, the reduced generator and the setup check from the registers.
// Depends on crcfg_pkg.
module crcfg_setup (
  input  logic [crcfg_pkg::POLY_W-1:0]   poly,
  input  logic [crcfg_pkg::CWIDTH_W-1:0] crc_width,
  input  logic [crcfg_pkg::FLEN_W-1:0]   frame_length,
  output crcfg_pkg::crcfg_setup_t        setup
);
  import crcfg_pkg::*;

  logic [CWIDTH_W-1:0] w_sat;
  logic [FLEN_W-1:0]   len_sat;
  logic [FCS_W-1:0]    wmask;
  logic                bad_len;
  logic                bad_poly;

  always_comb begin
    w_sat   = (32'(crc_width) > 32'(MAX_CRC_BITS)) ? CWIDTH_W'(MAX_CRC_BITS) : crc_width;
    len_sat = (32'(frame_length) > 32'(MAX_DATA_BITS)) ? FLEN_W'(MAX_DATA_BITS)
                                                       : frame_length;
    // A shift by the full width wraps to zero, so the mask becomes all ones.
    wmask   = (FCS_W'(1) << w_sat) - FCS_W'(1);

    bad_len  = (frame_length == '0) || (32'(frame_length) > 32'(MAX_DATA_BITS)) ||
               (crc_width == '0) || (32'(crc_width) > 32'(MAX_CRC_BITS)) ||
               (FLEN_W'(crc_width) >= frame_length);
    bad_poly = !poly[crc_width] || !poly[0];

    setup.wmask   = wmask;
    setup.topmask = (w_sat == '0) ? '0 : (FCS_W'(1) << (w_sat - CWIDTH_W'(1)));
    setup.gen     = poly[FCS_W-1:0] & wmask;
    setup.width   = w_sat;
    setup.len     = len_sat;
    setup.bad     = bad_len || bad_poly;
  end

endmodule

// ===== rtl/core/crcfg_cell.sv =====
// One division cell: shifts one message bit into the remainder per request.
// Depends on crcfg_pkg.
module crcfg_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  crcfg_pkg::crcfg_setup_t setup,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  crcfg_pkg::crcfg_stage_t in_stage,
  output logic                    out_valid,
  input  logic                    out_ready,
  output crcfg_pkg::crcfg_stage_t out_stage
);
  import crcfg_pkg::*;

  crcfg_stage_t stage_next;
  logic         top;

  // The cell can take a new request when it is empty or its content moves on.
  assign in_ready = !out_valid || out_ready;

  always_comb begin
    top              = |(in_stage.rem & setup.topmask);
    stage_next.action = in_stage.action;
    stage_next.rem    = ({in_stage.rem[FCS_W-2:0], in_stage.msg[MSG_W-1]} & setup.wmask) ^
                        (top ? setup.gen : '0);
    stage_next.msg    = {in_stage.msg[MSG_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_stage <= stage_next;
    end
  end

endmodule

// ===== rtl/core/crcfg_checker.sv =====
// Port-level checks for the CRC frame generator and checker, bound to the top.
// Depends on crcfg_pkg and crc_frame_generate_check_core.
module crcfg_core_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic                        req_ready,
  input  logic                        rsp_valid,
  input  logic                        rsp_ready,
  input  logic [crcfg_pkg::FCS_W-1:0] rsp_remainder,
  input  logic                        rsp_passed,
  input  logic                        rsp_bad_setup
);
  import crcfg_pkg::*;

  // A stalled response keeps its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_remainder) &&
      $stable(rsp_passed) && $stable(rsp_bad_setup))
    else $error("stalled response changed");

  // A pass needs a good setup and a zero syndrome.
  a_pass_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_passed |-> !rsp_bad_setup && (rsp_remainder == '0))
    else $error("pass reported with bad setup or nonzero syndrome");

  // The cell row only backs up when the output is full and stalled.
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("request blocked while output can drain");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind crc_frame_generate_check_core crcfg_core_checker u_crcfg_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_remainder (rsp.remainder),
  .rsp_passed    (rsp.passed),
  .rsp_bad_setup (rsp.bad_setup)
);
